/* rtl/bpa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

   // Pool geometry
   localparam int MAX_BLOCKS = 1024;
   localparam int IDX_W      = $clog2(MAX_BLOCKS);
   localparam int CNT_W      = IDX_W + 1;

   // Field widths
   localparam int BLEN_W  = 16;
   localparam int OWN_W   = 32;
   localparam int BYTES_W = 24;
   localparam int OP_W    = 3;
   localparam int CSR_W   = 2;
   localparam int DATA_W  = 32;
   localparam int DIV_W   = BYTES_W + 1;
   localparam int DCNT_W  = $clog2(DIV_W + 1);

   // Alloc gives up after this many wraps of the walk
   localparam logic [1:0] WRAP_ROUNDS = 2'd3;

   // Register indexes
   localparam logic [CSR_W-1:0] CSR_BLOCK_LEN   = 2'd0;
   localparam logic [CSR_W-1:0] CSR_BLOCK_COUNT = 2'd1;
   localparam logic [CSR_W-1:0] CSR_INITIAL_RUN = 2'd2;
   localparam logic [CSR_W-1:0] CSR_MY_ID       = 2'd3;

   // Operation codes
   typedef enum logic [OP_W-1:0] {
      OP_INIT      = 3'd0,
      OP_ALLOC     = 3'd1,
      OP_FREE      = 3'd2,
      OP_FREE_ALL  = 3'd3,
      OP_TRANSFER  = 3'd4,
      OP_TAKE      = 3'd5,
      OP_LENGTH    = 3'd6
   } op_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FMT,
      ST_DIV,
      ST_A_CHK,
      ST_A_EVAL,
      ST_A_REL,
      ST_A_END,
      ST_A_SPLIT,
      ST_F_RD,
      ST_F_EV,
      ST_LEN,
      ST_DONE
   } state_type;

   // Datapath commands
   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_SWEEP,
      CMD_SIMPLE,
      CMD_LEN_ISSUE,
      CMD_A_INIT,
      CMD_A_ISSUE,
      CMD_A_EVAL,
      CMD_A_REL,
      CMD_A_END,
      CMD_A_SPLIT,
      CMD_F_INIT,
      CMD_F_ISSUE,
      CMD_F_EVAL,
      CMD_PUSH
   } cmd_type;

   // Datapath status toward the controller
   typedef struct packed {
      logic [OP_W-1:0] in_op;
      logic [OP_W-1:0] op;
      logic            div_busy;
      logic            sweep_last;
      logic            a_go;
      logic            a_split;
      logic            f_more;
      logic            req_zero;
      logic            rsp_free;
   } status_type;

endpackage

`default_nettype wire

/* rtl/bpa_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module bpa_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [bpa_pkg::DIV_W-1:0]      dividend,
   input  wire logic [bpa_pkg::BLEN_W-1:0]     divisor,
   output logic                                busy,
   output logic [bpa_pkg::DIV_W-1:0]           quotient
);

   logic                          busy_ff, busy_in;
   logic [bpa_pkg::DCNT_W-1:0]    cnt_ff, cnt_in;
   logic [bpa_pkg::DIV_W-1:0]     q_ff, q_in;
   logic [bpa_pkg::BLEN_W-1:0]    r_ff, r_in;
   logic [bpa_pkg::BLEN_W:0]      shifted;
   logic [bpa_pkg::BLEN_W:0]      diff;
   logic                          fits;

   // One quotient bit per cycle, restoring
   always_comb begin
      shifted = {r_ff, q_ff[bpa_pkg::DIV_W-1]};
      diff    = shifted - {1'b0, divisor};
      fits    = shifted >= {1'b0, divisor};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = bpa_pkg::DCNT_W'(bpa_pkg::DIV_W);
         q_in    = dividend;
         r_in    = '0;
      end else if (busy_ff) begin
         q_in   = {q_ff[bpa_pkg::DIV_W-2:0], fits};
         r_in   = fits ? diff[bpa_pkg::BLEN_W-1:0] : shifted[bpa_pkg::BLEN_W-1:0];
         cnt_in = cnt_ff - bpa_pkg::DCNT_W'(1);
         if (cnt_ff == bpa_pkg::DCNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
   end

   assign busy     = busy_ff;
   assign quotient = q_ff;

endmodule

`default_nettype wire

/* rtl/bpa_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module bpa_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire bpa_pkg::cmd_type                  cmd,
   output bpa_pkg::status_type                    status,
   input  wire logic                              csr_we,
   input  wire logic [bpa_pkg::CSR_W-1:0]         csr_index,
   input  wire logic [bpa_pkg::DATA_W-1:0]        csr_data,
   input  wire logic [bpa_pkg::OP_W-1:0]          req_operation,
   input  wire logic [bpa_pkg::BYTES_W-1:0]       req_byte_offset,
   input  wire logic [bpa_pkg::BYTES_W-1:0]       req_request_bytes,
   input  wire logic [bpa_pkg::OWN_W-1:0]         req_owner_id,
   input  wire logic [bpa_pkg::IDX_W-1:0]         req_block_token,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_valid,
   output logic                                   rsp_ok,
   output logic [bpa_pkg::IDX_W-1:0]              rsp_block_index,
   output logic [bpa_pkg::BYTES_W-1:0]            rsp_alloc_bytes_out
);

   localparam int IW = bpa_pkg::IDX_W;
   localparam int CW = bpa_pkg::CNT_W;
   localparam int DW = bpa_pkg::DIV_W;

   // Configuration registers
   logic [bpa_pkg::BLEN_W-1:0]  blen_ff;
   logic [CW-1:0]               bcnt_ff;
   logic [CW-1:0]               irun_ff;
   logic [bpa_pkg::OWN_W-1:0]   myid_ff;
   logic [bpa_pkg::BLEN_W-1:0]  bl_eff;
   logic [CW-1:0]               bc_eff;
   logic [CW-1:0]               ir_eff;

   // Captured item
   logic [bpa_pkg::OP_W-1:0]    op_ff, op_in;
   logic [bpa_pkg::BYTES_W-1:0] reqb_ff, reqb_in;
   logic [bpa_pkg::OWN_W-1:0]   oid_ff, oid_in;
   logic [IW-1:0]               tok_ff, tok_in;

   // Divider
   logic                        div_start;
   logic [DW-1:0]               div_dividend;
   logic                        div_busy;
   logic [DW-1:0]               quot;
   logic                        in_range;
   logic [IW-1:0]               blk;

   // Walk state
   logic [IW-1:0]               nfp_ff, nfp_in;
   logic [IW-1:0]               p_ff, p_in;
   logic                        have_ff, have_in;
   logic [1:0]                  rounds_ff, rounds_in;
   logic [CW-1:0]               lenp_ff, lenp_in;
   logic [IW-1:0]               cur_ff, cur_in;
   logic                        curne_ff, curne_in;
   logic                        got_ff, got_in;
   logic [CW-1:0]               lencur_ff, lencur_in;
   logic [CW-1:0]               a_curp;
   logic [IW-1:0]               a_cur;
   logic [CW:0]                 a_nxtp;
   logic [IW-1:0]               a_nxt;
   logic                        a_rel;
   logic [CW-1:0]               a_sum;
   logic [CW-1:0]               a_rest;

   // Sweep and free_all state
   logic [IW-1:0]               sw_i_ff, sw_i_in;
   logic [CW-1:0]               sw_cnt_ff, sw_cnt_in;
   logic                        sw_all_ff, sw_all_in;
   logic [CW-1:0]               sw_rem;
   logic [IW-1:0]               fi_ff, fi_in;
   logic [CW:0]                 f_next;

   // Result and output registers
   logic                        res_ok_ff, res_ok_in;
   logic [IW-1:0]               res_idx_ff, res_idx_in;
   logic [bpa_pkg::BYTES_W-1:0] res_bytes_ff, res_bytes_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_ok_ff;
   logic [IW-1:0]               rsp_idx_ff;
   logic [bpa_pkg::BYTES_W-1:0] rsp_bytes_ff;

   // Memories
   logic [CW-1:0]               len_mem [bpa_pkg::MAX_BLOCKS];
   logic [bpa_pkg::OWN_W-1:0]   own_mem [bpa_pkg::MAX_BLOCKS];
   logic [bpa_pkg::BYTES_W-1:0] byt_mem [bpa_pkg::MAX_BLOCKS];
   logic [CW-1:0]               len_q;
   logic [bpa_pkg::OWN_W-1:0]   own_q;
   logic [bpa_pkg::BYTES_W-1:0] byt_q;
   logic [CW-1:0]               len_q_eff;
   logic [IW-1:0]               rd_addr;
   logic                        len_we, own_we, byt_we;
   logic [IW-1:0]               len_wa, own_wa, byt_wa;
   logic [CW-1:0]               len_wd;
   logic [bpa_pkg::OWN_W-1:0]   own_wd;
   logic [bpa_pkg::BYTES_W-1:0] byt_wd;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         blen_ff <= bpa_pkg::BLEN_W'(64);
         bcnt_ff <= CW'(bpa_pkg::MAX_BLOCKS);
         irun_ff <= CW'(1);
         myid_ff <= bpa_pkg::OWN_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            bpa_pkg::CSR_BLOCK_LEN:   blen_ff <= csr_data[bpa_pkg::BLEN_W-1:0];
            bpa_pkg::CSR_BLOCK_COUNT: bcnt_ff <= csr_data[CW-1:0];
            bpa_pkg::CSR_INITIAL_RUN: irun_ff <= csr_data[CW-1:0];
            bpa_pkg::CSR_MY_ID:       myid_ff <= csr_data[bpa_pkg::OWN_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective register values
   always_comb begin
      bl_eff = (blen_ff == '0) ? bpa_pkg::BLEN_W'(1) : blen_ff;
      if (bcnt_ff == '0) begin
         bc_eff = CW'(1);
      end else if (bcnt_ff > CW'(bpa_pkg::MAX_BLOCKS)) begin
         bc_eff = CW'(bpa_pkg::MAX_BLOCKS);
      end else begin
         bc_eff = bcnt_ff;
      end
      ir_eff = (irun_ff == '0) ? CW'(1) : irun_ff;
   end

   // Divider: block of an offset, or blocks needed for a request (rounded up)
   assign div_dividend = (req_operation == bpa_pkg::OP_ALLOC)
                       ? DW'(req_request_bytes) + DW'(bl_eff) - DW'(1)
                       : DW'(req_byte_offset);

   bpa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (bl_eff),
      .busy     (div_busy),
      .quotient (quot)
   );

   assign in_range  = quot < DW'(bc_eff);
   assign blk       = quot[IW-1:0];
   assign len_q_eff = (len_q == '0) ? CW'(1) : len_q;

   // Walk arithmetic
   always_comb begin
      a_curp = have_ff ? (CW'(p_ff) + lenp_ff) : CW'(nfp_ff);
      a_cur  = (a_curp < bc_eff) ? a_curp[IW-1:0] : '0;
      a_nxtp = (CW+1)'(cur_ff) + (CW+1)'(len_q_eff);
      a_nxt  = (a_nxtp < (CW+1)'(bc_eff)) ? a_nxtp[IW-1:0] : '0;
      a_rel  = have_ff && (!got_ff || curne_ff);
      a_sum  = lenp_ff + lencur_ff;
      a_rest = CW'(p_ff) + quot[CW-1:0];
      f_next = (CW+1)'(fi_ff) + (CW+1)'(len_q_eff);
      sw_rem = bc_eff - CW'(sw_i_ff);
   end

   // Command decoder
   always_comb begin
      op_in        = op_ff;
      reqb_in      = reqb_ff;
      oid_in       = oid_ff;
      tok_in       = tok_ff;
      nfp_in       = nfp_ff;
      p_in         = p_ff;
      have_in      = have_ff;
      rounds_in    = rounds_ff;
      lenp_in      = lenp_ff;
      cur_in       = cur_ff;
      curne_in     = curne_ff;
      got_in       = got_ff;
      lencur_in    = lencur_ff;
      sw_i_in      = sw_i_ff;
      sw_cnt_in    = sw_cnt_ff;
      sw_all_in    = sw_all_ff;
      fi_in        = fi_ff;
      res_ok_in    = res_ok_ff;
      res_idx_in   = res_idx_ff;
      res_bytes_in = res_bytes_ff;
      div_start    = 1'b0;
      rd_addr      = blk;
      len_we       = 1'b0;
      own_we       = 1'b0;
      byt_we       = 1'b0;
      len_wa       = p_ff;
      own_wa       = p_ff;
      byt_wa       = p_ff;
      len_wd       = '0;
      own_wd       = '0;
      byt_wd       = reqb_ff;
      unique case (cmd)
         bpa_pkg::CMD_LOAD: begin
            op_in     = req_operation;
            reqb_in   = req_request_bytes;
            oid_in    = req_owner_id;
            tok_in    = req_block_token;
            div_start = 1'b1;
            sw_i_in   = '0;
            sw_cnt_in = '0;
            sw_all_in = 1'b0;
         end
         bpa_pkg::CMD_SWEEP: begin
            len_we = 1'b1;
            own_we = 1'b1;
            byt_we = 1'b1;
            len_wa = sw_i_ff;
            own_wa = sw_i_ff;
            byt_wa = sw_i_ff;
            byt_wd = '0;
            if (sw_all_ff || (CW'(sw_i_ff) >= bc_eff)) begin
               len_wd = CW'(1);
            end else if (sw_cnt_ff == '0) begin
               len_wd    = (sw_rem < ir_eff) ? sw_rem : ir_eff;
               sw_cnt_in = ir_eff - CW'(1);
            end else begin
               len_wd    = '0;
               sw_cnt_in = sw_cnt_ff - CW'(1);
            end
            sw_i_in      = sw_i_ff + IW'(1);
            nfp_in       = '0;
            res_ok_in    = 1'b1;
            res_idx_in   = '0;
            res_bytes_in = '0;
         end
         bpa_pkg::CMD_SIMPLE: begin
            res_ok_in    = 1'b0;
            res_idx_in   = '0;
            res_bytes_in = '0;
            case (op_ff)
               bpa_pkg::OP_FREE, bpa_pkg::OP_TRANSFER: begin
                  if (in_range) begin
                     own_we     = 1'b1;
                     own_wa     = blk;
                     own_wd     = (op_ff == bpa_pkg::OP_FREE) ? '0 : oid_ff;
                     res_ok_in  = 1'b1;
                     res_idx_in = blk;
                  end
               end
               bpa_pkg::OP_TAKE: begin
                  if (CW'(tok_ff) < bc_eff) begin
                     res_ok_in  = 1'b1;
                     res_idx_in = tok_ff;
                  end
               end
               bpa_pkg::OP_LENGTH: begin
                  if (in_range) begin
                     res_ok_in    = 1'b1;
                     res_idx_in   = blk;
                     res_bytes_in = byt_q;
                  end
               end
               default: ;
            endcase
         end
         bpa_pkg::CMD_LEN_ISSUE: begin
            rd_addr = blk;
         end
         bpa_pkg::CMD_A_INIT: begin
            have_in   = 1'b0;
            rounds_in = bpa_pkg::WRAP_ROUNDS;
         end
         bpa_pkg::CMD_A_ISSUE: begin
            rd_addr  = a_cur;
            cur_in   = a_cur;
            curne_in = CW'(a_cur) != a_curp;
         end
         bpa_pkg::CMD_A_EVAL: begin
            lencur_in = len_q_eff;
            nfp_in    = a_nxt;
            if (a_nxtp >= (CW+1)'(bc_eff)) begin
               rounds_in = rounds_ff - 2'd1;
            end
            got_in = own_q == '0;
            if (own_q == '0) begin
               own_we = 1'b1;
               own_wa = cur_ff;
               own_wd = myid_ff;
            end
         end
         bpa_pkg::CMD_A_REL: begin
            if (a_rel) begin
               own_we  = 1'b1;
               own_wa  = p_ff;
               own_wd  = '0;
               have_in = 1'b0;
            end
            if (got_ff) begin
               if (have_ff && !a_rel) begin
                  len_we  = 1'b1;
                  len_wa  = p_ff;
                  len_wd  = a_sum;
                  lenp_in = a_sum;
               end else begin
                  have_in = 1'b1;
                  p_in    = cur_ff;
                  lenp_in = lencur_ff;
               end
            end
         end
         bpa_pkg::CMD_A_END: begin
            res_ok_in    = 1'b0;
            res_idx_in   = '0;
            res_bytes_in = '0;
            if (have_ff) begin
               if (DW'(lenp_ff) > quot) begin
                  // split off the excess as a free run
                  if (a_rest < CW'(bpa_pkg::MAX_BLOCKS)) begin
                     len_we = 1'b1;
                     len_wa = a_rest[IW-1:0];
                     len_wd = lenp_ff - quot[CW-1:0];
                     own_we = 1'b1;
                     own_wa = a_rest[IW-1:0];
                     own_wd = '0;
                  end
               end else if (DW'(lenp_ff) == quot) begin
                  byt_we     = 1'b1;
                  res_ok_in  = 1'b1;
                  res_idx_in = p_ff;
               end else begin
                  own_we = 1'b1;
                  own_wd = '0;
               end
            end
         end
         bpa_pkg::CMD_A_SPLIT: begin
            len_we     = 1'b1;
            len_wd     = quot[CW-1:0];
            lenp_in    = quot[CW-1:0];
            byt_we     = 1'b1;
            res_ok_in  = 1'b1;
            res_idx_in = p_ff;
         end
         bpa_pkg::CMD_F_INIT: begin
            fi_in = '0;
         end
         bpa_pkg::CMD_F_ISSUE: begin
            rd_addr = fi_ff;
         end
         bpa_pkg::CMD_F_EVAL: begin
            if (own_q == oid_ff) begin
               own_we = 1'b1;
               own_wa = fi_ff;
               own_wd = '0;
            end
            fi_in        = f_next[IW-1:0];
            res_ok_in    = 1'b1;
            res_idx_in   = '0;
            res_bytes_in = '0;
         end
         default: ;
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd == bpa_pkg::CMD_PUSH) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         nfp_ff       <= '0;
         sw_i_ff      <= '0;
         sw_cnt_ff    <= '0;
         sw_all_ff    <= 1'b1;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         nfp_ff       <= nfp_in;
         sw_i_ff      <= sw_i_in;
         sw_cnt_ff    <= sw_cnt_in;
         sw_all_ff    <= sw_all_in;
      end
      if (cmd == bpa_pkg::CMD_PUSH) begin
         rsp_ok_ff    <= res_ok_ff;
         rsp_idx_ff   <= res_idx_ff;
         rsp_bytes_ff <= res_bytes_ff;
      end
      op_ff        <= op_in;
      reqb_ff      <= reqb_in;
      oid_ff       <= oid_in;
      tok_ff       <= tok_in;
      p_ff         <= p_in;
      have_ff      <= have_in;
      rounds_ff    <= rounds_in;
      lenp_ff      <= lenp_in;
      cur_ff       <= cur_in;
      curne_ff     <= curne_in;
      got_ff       <= got_in;
      lencur_ff    <= lencur_in;
      fi_ff        <= fi_in;
      res_ok_ff    <= res_ok_in;
      res_idx_ff   <= res_idx_in;
      res_bytes_ff <= res_bytes_in;
   end

   // Run table memories
   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[len_wa] <= len_wd;
      end
      len_q <= len_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (own_we) begin
         own_mem[own_wa] <= own_wd;
      end
      own_q <= own_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (byt_we) begin
         byt_mem[byt_wa] <= byt_wd;
      end
      byt_q <= byt_mem[rd_addr];
   end

   // Status
   always_comb begin
      status.in_op      = req_operation;
      status.op         = op_ff;
      status.div_busy   = div_busy;
      status.sweep_last = sw_i_ff == IW'(bpa_pkg::MAX_BLOCKS - 1);
      status.a_go       = (!have_ff || (DW'(lenp_ff) < quot)) && (rounds_ff != 2'd0);
      status.a_split    = have_ff && (DW'(lenp_ff) > quot);
      status.f_more     = f_next < (CW+1)'(bc_eff);
      status.req_zero   = reqb_ff == '0;
      status.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_ok              = rsp_ok_ff;
   assign rsp_block_index     = rsp_idx_ff;
   assign rsp_alloc_bytes_out = rsp_bytes_ff;

endmodule

`default_nettype wire

/* rtl/bpa_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module bpa_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire bpa_pkg::status_type   status,
   output bpa_pkg::cmd_type           cmd
);

   bpa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bpa_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = bpa_pkg::CMD_NONE;
      req_stall = 1'b1;
      unique case (state_ff)
         bpa_pkg::ST_CLEAR: begin
            cmd = bpa_pkg::CMD_SWEEP;
            if (status.sweep_last) begin
               state_in = bpa_pkg::ST_IDLE;
            end
         end
         bpa_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd = bpa_pkg::CMD_LOAD;
               if (status.in_op == bpa_pkg::OP_INIT) begin
                  state_in = bpa_pkg::ST_FMT;
               end else begin
                  state_in = bpa_pkg::ST_DIV;
               end
            end
         end
         bpa_pkg::ST_FMT: begin
            cmd = bpa_pkg::CMD_SWEEP;
            if (status.sweep_last) begin
               state_in = bpa_pkg::ST_DONE;
            end
         end
         bpa_pkg::ST_DIV: begin
            if (!status.div_busy) begin
               unique case (status.op)
                  bpa_pkg::OP_ALLOC: begin
                     if (status.req_zero) begin
                        cmd      = bpa_pkg::CMD_SIMPLE;
                        state_in = bpa_pkg::ST_DONE;
                     end else begin
                        cmd      = bpa_pkg::CMD_A_INIT;
                        state_in = bpa_pkg::ST_A_CHK;
                     end
                  end
                  bpa_pkg::OP_FREE_ALL: begin
                     cmd      = bpa_pkg::CMD_F_INIT;
                     state_in = bpa_pkg::ST_F_RD;
                  end
                  bpa_pkg::OP_LENGTH: begin
                     cmd      = bpa_pkg::CMD_LEN_ISSUE;
                     state_in = bpa_pkg::ST_LEN;
                  end
                  default: begin
                     cmd      = bpa_pkg::CMD_SIMPLE;
                     state_in = bpa_pkg::ST_DONE;
                  end
               endcase
            end
         end
         bpa_pkg::ST_LEN: begin
            cmd      = bpa_pkg::CMD_SIMPLE;
            state_in = bpa_pkg::ST_DONE;
         end
         bpa_pkg::ST_A_CHK: begin
            if (status.a_go) begin
               cmd      = bpa_pkg::CMD_A_ISSUE;
               state_in = bpa_pkg::ST_A_EVAL;
            end else begin
               state_in = bpa_pkg::ST_A_END;
            end
         end
         bpa_pkg::ST_A_EVAL: begin
            cmd      = bpa_pkg::CMD_A_EVAL;
            state_in = bpa_pkg::ST_A_REL;
         end
         bpa_pkg::ST_A_REL: begin
            cmd      = bpa_pkg::CMD_A_REL;
            state_in = bpa_pkg::ST_A_CHK;
         end
         bpa_pkg::ST_A_END: begin
            cmd = bpa_pkg::CMD_A_END;
            if (status.a_split) begin
               state_in = bpa_pkg::ST_A_SPLIT;
            end else begin
               state_in = bpa_pkg::ST_DONE;
            end
         end
         bpa_pkg::ST_A_SPLIT: begin
            cmd      = bpa_pkg::CMD_A_SPLIT;
            state_in = bpa_pkg::ST_DONE;
         end
         bpa_pkg::ST_F_RD: begin
            cmd      = bpa_pkg::CMD_F_ISSUE;
            state_in = bpa_pkg::ST_F_EV;
         end
         bpa_pkg::ST_F_EV: begin
            cmd = bpa_pkg::CMD_F_EVAL;
            if (status.f_more) begin
               state_in = bpa_pkg::ST_F_RD;
            end else begin
               state_in = bpa_pkg::ST_DONE;
            end
         end
         bpa_pkg::ST_DONE: begin
            if (status.rsp_free) begin
               cmd      = bpa_pkg::CMD_PUSH;
               state_in = bpa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bpa_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/block_pool_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake              Payload
// req       req_valid/req_stall    operation, byte_offset, request_bytes, owner_id, block_token
// rsp       rsp_valid/rsp_stall    ok, block_index, alloc_bytes_out
// csr       csr_we                 csr_index, csr_data
//
// One item at a time. Every item except init first runs the 25-bit serial
// divider (offset to block, or bytes to blocks). Alloc then reads, evaluates
// and releases or merges each run visited, then ends and may split; free_all
// reads and evaluates each run head. Init and the pass after reset sweep all
// 1024 table entries, one per cycle; after reset no item is taken until that sweep ends.
// A result waits in the output register; a stalled rsp holds the next item
// at its last step.

module block_pool_allocator (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [bpa_pkg::CSR_W-1:0]         csr_index,
   input  wire logic [bpa_pkg::DATA_W-1:0]        csr_data,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [bpa_pkg::OP_W-1:0]          req_operation,
   input  wire logic [bpa_pkg::BYTES_W-1:0]       req_byte_offset,
   input  wire logic [bpa_pkg::BYTES_W-1:0]       req_request_bytes,
   input  wire logic [bpa_pkg::OWN_W-1:0]         req_owner_id,
   input  wire logic [bpa_pkg::IDX_W-1:0]         req_block_token,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_ok,
   output logic [bpa_pkg::IDX_W-1:0]              rsp_block_index,
   output logic [bpa_pkg::BYTES_W-1:0]            rsp_alloc_bytes_out
);

   bpa_pkg::cmd_type    cmd;
   bpa_pkg::status_type status;

   bpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bpa_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_operation       (req_operation),
      .req_byte_offset     (req_byte_offset),
      .req_request_bytes   (req_request_bytes),
      .req_owner_id        (req_owner_id),
      .req_block_token     (req_block_token),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_ok              (rsp_ok),
      .rsp_block_index     (rsp_block_index),
      .rsp_alloc_bytes_out (rsp_alloc_bytes_out)
   );

endmodule

`default_nettype wire

/* verif/block_pool_allocator_test.sv */
`timescale 1ns / 1ps

module block_pool_allocator_test;

   localparam int MAXB = bpa_pkg::MAX_BLOCKS;
   localparam int N_RANDOM = 1800;

   // expected result of one item
   typedef struct {
      logic                         ok;
      logic [bpa_pkg::IDX_W-1:0]    blk;
      logic [bpa_pkg::BYTES_W-1:0]  nbytes;
   } outcome_type;

   // directed stimulus row; chk set where the answer is typed in
   typedef struct {
      logic [bpa_pkg::OP_W-1:0]     op;
      logic [bpa_pkg::BYTES_W-1:0]  offs;
      logic [bpa_pkg::BYTES_W-1:0]  rbytes;
      logic [bpa_pkg::OWN_W-1:0]    oid;
      logic [bpa_pkg::IDX_W-1:0]    tok;
      bit                           chk;
      outcome_type                  want;
   } row_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         csr_we = 1'b0;
   logic [bpa_pkg::CSR_W-1:0]    csr_index = '0;
   logic [bpa_pkg::DATA_W-1:0]   csr_data = '0;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [bpa_pkg::OP_W-1:0]     req_operation = '0;
   logic [bpa_pkg::BYTES_W-1:0]  req_byte_offset = '0;
   logic [bpa_pkg::BYTES_W-1:0]  req_request_bytes = '0;
   logic [bpa_pkg::OWN_W-1:0]    req_owner_id = '0;
   logic [bpa_pkg::IDX_W-1:0]    req_block_token = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic                         rsp_ok;
   logic [bpa_pkg::IDX_W-1:0]    rsp_block_index;
   logic [bpa_pkg::BYTES_W-1:0]  rsp_alloc_bytes_out;

   block_pool_allocator dut (.*);

   always #10 clock = ~clock;

   // shadow of the pool
   logic [15:0]   sh_block_len;
   logic [10:0]   sh_block_count;
   logic [10:0]   sh_initial_run;
   logic [31:0]   sh_my_id;
   int unsigned   sh_next_fit;
   int unsigned   sh_run_len [MAXB];
   logic [31:0]   sh_owner [MAXB];
   logic [23:0]   sh_bytes [MAXB];

   outcome_type pending_results[$];
   int          error_count = 0;
   bit          rx_hold = 1'b1;
   int          rx_long_hold = 0;

   function automatic int unsigned pool_blocks();
      int unsigned c;
      c = sh_block_count;
      if (c < 1) c = 1;
      if (c > MAXB) c = MAXB;
      return c;
   endfunction

   function automatic int unsigned run_at(int unsigned i);
      if (i >= MAXB) return 1;
      return (sh_run_len[i] == 0) ? 1 : sh_run_len[i];
   endfunction

   function automatic void pool_reset();
      sh_block_len = 16'd64;
      sh_block_count = 11'd1024;
      sh_initial_run = 11'd1;
      sh_my_id = 32'd1;
      sh_next_fit = 0;
      for (int i = 0; i < MAXB; i++) begin
         sh_run_len[i] = 1;
         sh_owner[i] = '0;
         sh_bytes[i] = '0;
      end
   endfunction

   function automatic void pool_format();
      int unsigned bc, ir;
      bc = pool_blocks();
      ir = (sh_initial_run == 0) ? 1 : sh_initial_run;
      for (int i = 0; i < MAXB; i++) begin
         sh_run_len[i] = (i >= bc) ? 1 : 0;
         sh_owner[i] = '0;
         sh_bytes[i] = '0;
      end
      for (int unsigned i = 0; i < bc; i += ir)
         sh_run_len[i] = (bc - i < ir) ? bc - i : ir;
      sh_next_fit = 0;
   endfunction

   // next-fit walk with coalescing; returns head or -1
   function automatic int pool_alloc(int unsigned req);
      int unsigned bc, bl, ub, p, rounds, curp, cur, nxtp, nxt, rest;
      bit have, got;
      bc = pool_blocks();
      bl = (sh_block_len == 0) ? 1 : sh_block_len;
      p = 0;
      rounds = 3;
      have = 0;
      if (req == 0) return -1;
      ub = (req + bl - 1) / bl;
      while ((!have || run_at(p) < ub) && rounds != 0) begin
         curp = have ? p + run_at(p) : sh_next_fit;
         cur = (curp < bc) ? curp : 0;
         nxtp = cur + run_at(cur);
         nxt = (nxtp < bc) ? nxtp : 0;
         sh_next_fit = nxt;
         got = (sh_owner[cur] == 0);
         if (got) sh_owner[cur] = sh_my_id;
         if (have && (!got || cur != curp)) begin
            sh_owner[p] = '0;
            have = 0;
         end
         if (nxt != nxtp) rounds--;
         if (got) begin
            if (have) sh_run_len[p] = run_at(p) + run_at(cur);
            else begin
               have = 1;
               p = cur;
            end
         end
      end
      if (!have) return -1;
      if (run_at(p) > ub) begin
         rest = p + ub;
         if (rest < MAXB) begin
            sh_run_len[rest] = run_at(p) - ub;
            sh_owner[rest] = '0;
         end
         sh_run_len[p] = ub;
      end
      if (run_at(p) == ub) sh_bytes[p] = req[23:0];
      if (run_at(p) < ub) begin
         sh_owner[p] = '0;
         return -1;
      end
      return p;
   endfunction

   // expected result of one item, state updated
   function automatic outcome_type pool_apply(logic [bpa_pkg::OP_W-1:0] op, logic [23:0] offs,
                                              logic [23:0] rbytes, logic [31:0] oid,
                                              logic [9:0] tok);
      outcome_type r;
      int unsigned bc, blk, i, h;
      int head;
      bit in_range;
      bc = pool_blocks();
      blk = offs / ((sh_block_len == 0) ? 1 : sh_block_len);
      in_range = blk < bc;
      r.ok = 0;
      r.blk = '0;
      r.nbytes = '0;
      case (op)
         bpa_pkg::OP_INIT: begin
            pool_format();
            r.ok = 1;
         end
         bpa_pkg::OP_ALLOC: begin
            head = pool_alloc(32'(rbytes));
            if (head >= 0) begin
               r.ok = 1;
               r.blk = head[9:0];
            end
         end
         bpa_pkg::OP_FREE: if (in_range) begin
            sh_owner[blk] = '0;
            r.ok = 1;
            r.blk = blk[9:0];
         end
         bpa_pkg::OP_FREE_ALL: begin
            i = 0;
            do begin
               h = i;
               i += run_at(h);
               if (sh_owner[h] == oid) sh_owner[h] = '0;
            end while (i < bc);
            r.ok = 1;
         end
         bpa_pkg::OP_TRANSFER: if (in_range) begin
            sh_owner[blk] = oid;
            r.ok = 1;
            r.blk = blk[9:0];
         end
         bpa_pkg::OP_TAKE: if (tok < bc) begin
            r.ok = 1;
            r.blk = tok;
         end
         bpa_pkg::OP_LENGTH: if (in_range) begin
            r.ok = 1;
            r.blk = blk[9:0];
            r.nbytes = sh_bytes[blk];
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int exp);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $time);
      error_count++;
   endtask

   task automatic write_reg(input logic [bpa_pkg::CSR_W-1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         bpa_pkg::CSR_BLOCK_LEN:   sh_block_len = val[15:0];
         bpa_pkg::CSR_BLOCK_COUNT: sh_block_count = val[10:0];
         bpa_pkg::CSR_INITIAL_RUN: sh_initial_run = val[10:0];
         default:                  sh_my_id = val;
      endcase
   endtask

   // drive one item; caller is at a falling edge, valid stays up for a follow-on item
   task automatic send_item(input logic [bpa_pkg::OP_W-1:0] op, input logic [23:0] offs,
                            input logic [23:0] rbytes, input logic [31:0] oid,
                            input logic [9:0] tok, input bit chk, input outcome_type want,
                            input bit do_gap);
      outcome_type e;
      int gap;
      gap = do_gap ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_byte_offset <= offs;
      req_request_bytes <= rbytes;
      req_owner_id <= oid;
      req_block_token <= tok;
      do @(posedge clock); while (req_stall);
      e = pool_apply(op, offs, rbytes, oid, tok);
      if (chk && (e.ok !== want.ok || e.blk !== want.blk || e.nbytes !== want.nbytes))
         report_mismatch("typed-in row", {e.ok, e.blk}, {want.ok, want.blk});
      pending_results.push_back(e);
      @(negedge clock);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (pending_results.size() != 0 && guard < 2000000) begin
         @(negedge clock);
         guard++;
      end
      if (pending_results.size() != 0)
         report_mismatch("results missing", 0, pending_results.size());
      repeat (200) @(negedge clock);
   endtask

   // receiver stall pattern
   initial begin
      int hold;
      forever begin
         @(negedge clock);
         if (rx_long_hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (rx_long_hold) @(negedge clock);
            rx_long_hold = 0;
            rsp_stall <= 1'b0;
         end else if (rx_hold) begin
            hold = $urandom_range(0, 8);
            if (hold != 0) begin
               rsp_stall <= 1'b1;
               repeat (hold) @(negedge clock);
            end
            rsp_stall <= 1'b0;
         end else rsp_stall <= 1'b0;
      end
   end

   // result checker
   always @(posedge clock) begin
      outcome_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", rsp_block_index, -1);
         end else begin
            e = pending_results.pop_front();
            if (rsp_ok !== e.ok) report_mismatch("ok", rsp_ok, e.ok);
            if (rsp_block_index !== e.blk)
               report_mismatch("block_index", rsp_block_index, e.blk);
            if (rsp_alloc_bytes_out !== e.nbytes)
               report_mismatch("alloc_bytes_out", rsp_alloc_bytes_out, e.nbytes);
         end
      end
   end

   // run limit
   initial begin
      #2s;
      $display("** block_pool_allocator: FAILED **");
      $finish;
   end

   function automatic outcome_type mk(logic ok, int blk, int nb);
      outcome_type r;
      r.ok = ok;
      r.blk = blk[9:0];
      r.nbytes = nb[23:0];
      return r;
   endfunction

   // random item with mostly useful content
   task automatic random_item(input bit gaps);
      logic [bpa_pkg::OP_W-1:0] op;
      logic [23:0] offs, rb;
      logic [31:0] oid, rnd;
      int unsigned bc, bl, k;
      outcome_type none;
      none = mk(0, 0, 0);
      bc = pool_blocks();
      bl = (sh_block_len == 0) ? 1 : sh_block_len;
      k = $urandom_range(0, 99);
      if (k < 2) op = bpa_pkg::OP_INIT;
      else if (k < 40) op = bpa_pkg::OP_ALLOC;
      else if (k < 55) op = bpa_pkg::OP_FREE;
      else if (k < 60) op = bpa_pkg::OP_FREE_ALL;
      else if (k < 68) op = bpa_pkg::OP_TRANSFER;
      else if (k < 76) op = bpa_pkg::OP_TAKE;
      else if (k < 97) op = bpa_pkg::OP_LENGTH;
      else op = 3'd7;
      rnd = $urandom;
      if ($urandom_range(0, 9) == 0) offs = rnd[23:0];
      else offs = 24'(($urandom_range(0, bc) * bl + $urandom_range(0, bl - 1)) & 24'hFFFFFF);
      rnd = $urandom;
      case ($urandom_range(0, 9))
         0: rb = rnd[23:0] | 24'h1;
         1: rb = 24'hFFFFFF;
         2, 3: rb = 24'($urandom_range(1, 4 * bl));
         default: rb = 24'($urandom_range(1, bl));
      endcase
      case ($urandom_range(0, 5))
         0: oid = 0;
         1: oid = $urandom;
         default: oid = sh_my_id;
      endcase
      rnd = $urandom;
      send_item(op, offs, rb, oid, rnd[9:0], 0, none, gaps);
   endtask

   row_type dir_rows[$];

   initial begin
      outcome_type none;
      none = mk(0, 0, 0);
      pool_reset();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table, reset configuration: 64-byte blocks, 1024 blocks
      dir_rows = '{
         '{bpa_pkg::OP_TAKE, 0, 1, 0, 10'h3FF, 1, '{1, 10'h3FF, 0}},
         '{bpa_pkg::OP_TAKE, 0, 1, 0, 0, 1, '{1, 0, 0}},
         '{bpa_pkg::OP_LENGTH, 24'hFFFFFF, 1, 0, 0, 1, '{0, 0, 0}},
         '{bpa_pkg::OP_LENGTH, 24'd65535, 1, 0, 0, 1, '{1, 10'd1023, 0}},
         '{bpa_pkg::OP_ALLOC, 0, 0, 0, 0, 1, '{0, 0, 0}},
         '{bpa_pkg::OP_ALLOC, 0, 1, 0, 0, 0, '{0, 0, 0}},
         '{bpa_pkg::OP_ALLOC, 0, 24'd200, 0, 0, 0, '{0, 0, 0}},
         '{bpa_pkg::OP_LENGTH, 24'd64, 1, 0, 0, 0, '{0, 0, 0}},
         '{bpa_pkg::OP_ALLOC, 0, 24'hFFFFFF, 0, 0, 0, '{0, 0, 0}},
         '{bpa_pkg::OP_FREE, 24'd64, 1, 0, 0, 1, '{1, 1, 0}},
         '{bpa_pkg::OP_FREE, 24'hFFFFFF, 1, 0, 0, 1, '{0, 0, 0}},
         '{bpa_pkg::OP_TRANSFER, 0, 1, 32'hFFFFFFFF, 0, 1, '{1, 0, 0}},
         '{bpa_pkg::OP_TRANSFER, 24'hFFFFFF, 1, 32'hFFFFFFFF, 0, 1, '{0, 0, 0}},
         '{bpa_pkg::OP_FREE_ALL, 0, 1, 32'hFFFFFFFF, 0, 1, '{1, 0, 0}},
         '{bpa_pkg::OP_FREE_ALL, 0, 1, 32'd1, 0, 1, '{1, 0, 0}},
         '{3'd7, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF, 10'h3FF, 1, '{0, 0, 0}},
         '{bpa_pkg::OP_INIT, 0, 1, 0, 0, 1, '{1, 0, 0}},
         '{bpa_pkg::OP_ALLOC, 0, 24'd64, 0, 0, 1, '{1, 0, 0}},
         '{bpa_pkg::OP_LENGTH, 24'd63, 1, 0, 0, 1, '{1, 0, 24'd64}}
      };
      foreach (dir_rows[i])
         send_item(dir_rows[i].op, dir_rows[i].offs, dir_rows[i].rbytes,
                   dir_rows[i].oid, dir_rows[i].tok, dir_rows[i].chk,
                   dir_rows[i].want, 1);
      drain();

      // configuration phases, extremes included
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               write_reg(bpa_pkg::CSR_BLOCK_LEN, 32'd16);
               write_reg(bpa_pkg::CSR_BLOCK_COUNT, 32'd64);
               write_reg(bpa_pkg::CSR_INITIAL_RUN, 32'd4);
               write_reg(bpa_pkg::CSR_MY_ID, 32'hFFFFFFFF);
            end
            1: begin
               write_reg(bpa_pkg::CSR_BLOCK_LEN, 32'd0);
               write_reg(bpa_pkg::CSR_BLOCK_COUNT, 32'd0);
               write_reg(bpa_pkg::CSR_INITIAL_RUN, 32'd0);
               write_reg(bpa_pkg::CSR_MY_ID, 32'd0);
            end
            2: begin
               write_reg(bpa_pkg::CSR_BLOCK_LEN, 32'd65535);
               write_reg(bpa_pkg::CSR_BLOCK_COUNT, 32'd2047);
               write_reg(bpa_pkg::CSR_INITIAL_RUN, 32'd2047);
               write_reg(bpa_pkg::CSR_MY_ID, 32'd1);
            end
            3: begin
               write_reg(bpa_pkg::CSR_BLOCK_LEN, 32'd1);
               write_reg(bpa_pkg::CSR_BLOCK_COUNT, 32'd24);
               write_reg(bpa_pkg::CSR_INITIAL_RUN, 32'd1);
               write_reg(bpa_pkg::CSR_MY_ID, 32'h5A5A5A5A);
            end
            4: begin
               write_reg(bpa_pkg::CSR_BLOCK_LEN, 32'd100);
               write_reg(bpa_pkg::CSR_BLOCK_COUNT, 32'd37);
               write_reg(bpa_pkg::CSR_INITIAL_RUN, 32'd5);
               write_reg(bpa_pkg::CSR_MY_ID, 32'd7);
            end
            default: begin
               write_reg(bpa_pkg::CSR_BLOCK_LEN, 32'd32);
               write_reg(bpa_pkg::CSR_BLOCK_COUNT, 32'd1024);
               write_reg(bpa_pkg::CSR_INITIAL_RUN, 32'd1024);
               write_reg(bpa_pkg::CSR_MY_ID, 32'd3);
            end
         endcase
         @(negedge clock);
         send_item(bpa_pkg::OP_INIT, 0, 1, 0, 0, 0, none, 1);
         // long receiver hold while items keep coming
         if (ph == 1) rx_long_hold = 300;
         for (int n = 0; n < N_RANDOM / 6; n++) begin
            // sender pause until all results are back
            if (n == 150) begin
               req_valid <= 1'b0;
               @(negedge clock);
               while (pending_results.size() != 0) @(negedge clock);
            end
            random_item(1);
         end
         drain();
      end

      if (error_count == 0) $display("** block_pool_allocator: PASSED **");
      else $display("** block_pool_allocator: FAILED **");
      $finish;
   end

endmodule

/* files.f */
rtl/bpa_pkg.sv
rtl/bpa_div.sv
rtl/bpa_datapath.sv
rtl/bpa_ctrl.sv
rtl/block_pool_allocator.sv
verif/block_pool_allocator_test.sv
